@@ rtl/sbc_pkg.sv @@
// ----------------------------------------------------------------------------
// sbc_pkg
// Types, constants and helpers shared by the sphere/box collision pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package sbc_pkg;

    localparam int CW      = 24;          // coordinate width
    localparam int RW      = 20;          // radius / register width
    localparam int D2W     = 2 * RW;      // squared distance width
    localparam int SQRT_N  = RW;          // one root bit per stage
    localparam int DIV_N   = D2W;         // one quotient bit per stage
    localparam int SUMW    = D2W + 2;     // final add width

    localparam logic [RW-1:0] FOOT_RESET = 20'd2560;
    localparam logic [RW-1:0] STEP_RESET = 20'd12800;

    typedef enum logic [1:0] {
        OC_NONE = 2'd0,
        OC_STEP = 2'd1,
        OC_PUSH = 2'd2,
        OC_ZERO = 2'd3
    } t_outcome;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] pz;
        logic signed [CW-1:0] ny;
        t_outcome             outcome;
        logic                 sx;
        logic                 sz;
        logic [RW-1:0]        ax;
        logic [RW-1:0]        az;
        logic [RW-1:0]        r;
    } t_side;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] hi;
        logic signed [SUMW-1:0] lo;
        hi = SUMW'((64'sd1 <<< (CW - 1)) - 64'sd1);
        lo = -hi - SUMW'(1);
        if (v > hi) begin
            return hi[CW-1:0];
        end else if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/sbc_sqrt.sv @@
// ----------------------------------------------------------------------------
// sbc_sqrt
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module sbc_sqrt (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [sbc_pkg::D2W-1:0]  i_d2,
    output logic      [sbc_pkg::RW-1:0]   o_root
);
    import sbc_pkg::*;

    logic [D2W-1:0] r_n    [0:SQRT_N-1];
    logic [RW+1:0]  r_rem  [0:SQRT_N-1];
    logic [RW-1:0]  r_root [0:SQRT_N-1];

    for (genvar g = 0; g < SQRT_N; g++) begin : g_stage
        logic [D2W-1:0] w_n;
        logic [RW+1:0]  w_rem;
        logic [RW-1:0]  w_root;
        logic [RW+3:0]  t_rem;
        logic [RW+3:0]  t_trial;
        logic [RW+1:0]  n_rem;
        logic [RW-1:0]  n_root;

        if (g == 0) begin : g_first
            assign w_n    = i_d2;
            assign w_rem  = '0;
            assign w_root = '0;
        end else begin : g_next
            assign w_n    = r_n[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
        end

        always_comb begin
            t_rem   = {w_rem, w_n[D2W-1:D2W-2]};
            t_trial = {2'b00, w_root, 2'b01};
            if (t_rem >= t_trial) begin
                n_rem  = (RW+2)'(t_rem - t_trial);
                n_root = {w_root[RW-2:0], 1'b1};
            end else begin
                n_rem  = t_rem[RW+1:0];
                n_root = {w_root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g]    <= {w_n[D2W-3:0], 2'b00};
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
            end
        end
    end

    assign o_root = r_root[SQRT_N-1];

endmodule
`default_nettype wire

@@ rtl/sbc_div.sv @@
// ----------------------------------------------------------------------------
// sbc_div
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module sbc_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [sbc_pkg::D2W-1:0]  i_num,
    input  wire logic [sbc_pkg::RW-1:0]   i_den,
    output logic      [sbc_pkg::D2W-1:0]  o_quo
);
    import sbc_pkg::*;

    logic [D2W-1:0] r_n   [0:DIV_N-1];
    logic [RW-1:0]  r_rem [0:DIV_N-1];
    logic [D2W-1:0] r_quo [0:DIV_N-1];
    logic [RW-1:0]  r_den [0:DIV_N-1];

    for (genvar g = 0; g < DIV_N; g++) begin : g_stage
        logic [D2W-1:0] w_n;
        logic [RW-1:0]  w_rem;
        logic [D2W-1:0] w_quo;
        logic [RW-1:0]  w_den;
        logic [RW:0]    t_rem;
        logic [RW-1:0]  n_rem;
        logic           n_bit;

        if (g == 0) begin : g_first
            assign w_n   = i_num;
            assign w_rem = '0;
            assign w_quo = '0;
            assign w_den = i_den;
        end else begin : g_next
            assign w_n   = r_n[g-1];
            assign w_rem = r_rem[g-1];
            assign w_quo = r_quo[g-1];
            assign w_den = r_den[g-1];
        end

        always_comb begin
            t_rem = {w_rem, w_n[D2W-1]};
            if (t_rem >= {1'b0, w_den}) begin
                n_rem = RW'(t_rem - {1'b0, w_den});
                n_bit = 1'b1;
            end else begin
                n_rem = t_rem[RW-1:0];
                n_bit = 1'b0;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g]   <= {w_n[D2W-2:0], 1'b0};
                r_rem[g] <= n_rem;
                r_quo[g] <= {w_quo[D2W-2:0], n_bit};
                r_den[g] <= w_den;
            end
        end
    end

    assign o_quo = r_quo[DIV_N-1];

endmodule
`default_nettype wire

@@ rtl/sphere_box_collision_resolve.sv @@
// Pipeline: 3 front stages, 20 root stages, 1 multiply stage, 40 divide stages
// and 1 output stage from input beat to result beat.
// Throughput: one beat per cycle; the whole pipeline advances on one enable
// that drops only while a finished result waits on m_axis_tready.
// Reset: synchronous active low, clears valid bits and loads the register
// defaults (foot_offset 10.0, max_step_rise 50.0).
// ----------------------------------------------------------------------------
// sphere_box_collision_resolve
// Sphere versus axis-aligned box collision response: step up or push out.
// ----------------------------------------------------------------------------
`default_nettype none
module sphere_box_collision_resolve (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // centre_x, centre_y, centre_z, radius, box_min_x/y/z, box_max_x/y/z, pad
    input  wire logic [239:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // new_x, new_y, new_z
    output logic      [71:0]  m_axis_tdata,
    // outcome
    output logic      [1:0]   m_axis_tuser
);
    import sbc_pkg::*;

    logic [RW-1:0] r_foot;
    logic [RW-1:0] r_step;
    logic          en;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {12'd0, r_step} : {12'd0, r_foot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_foot <= FOOT_RESET;
            r_step <= STEP_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                r_step <= pwdata[RW-1:0];
            end else begin
                r_foot <= pwdata[RW-1:0];
            end
        end
    end

    // stage 1: clamp
    logic signed [CW-1:0] in_px, in_py, in_pz, in_x0, in_y0, in_z0, in_x1, in_y1, in_z1;
    logic [RW-1:0]        in_r;

    assign in_px = s_axis_tdata[23:0];
    assign in_py = s_axis_tdata[47:24];
    assign in_pz = s_axis_tdata[71:48];
    assign in_r  = s_axis_tdata[91:72];
    assign in_x0 = s_axis_tdata[115:92];
    assign in_y0 = s_axis_tdata[139:116];
    assign in_z0 = s_axis_tdata[163:140];
    assign in_x1 = s_axis_tdata[187:164];
    assign in_y1 = s_axis_tdata[211:188];
    assign in_z1 = s_axis_tdata[235:212];

    function automatic logic signed [CW:0] off_axis(input logic signed [CW-1:0] v,
                                                    input logic signed [CW-1:0] lo,
                                                    input logic signed [CW-1:0] hi);
        logic signed [CW-1:0] c;
        if (v < lo) begin
            c = lo;
        end else if (v > hi) begin
            c = hi;
        end else begin
            c = v;
        end
        return (CW+1)'(v) - (CW+1)'(c);
    endfunction

    logic                 r_v1;
    logic signed [CW-1:0] r1_px, r1_py, r1_pz, r1_y1;
    logic [RW-1:0]        r1_r;
    logic signed [CW:0]   r1_dx, r1_dy, r1_dz;
    logic signed [CW+2:0] r1_rise;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_px   <= in_px;
            r1_py   <= in_py;
            r1_pz   <= in_pz;
            r1_y1   <= in_y1;
            r1_r    <= in_r;
            r1_dx   <= off_axis(in_px, in_x0, in_x1);
            r1_dy   <= off_axis(in_py, in_y0, in_y1);
            r1_dz   <= off_axis(in_pz, in_z0, in_z1);
            r1_rise <= (CW+3)'(in_y1) - (CW+3)'(in_py) + (CW+3)'({1'b0, r_foot});
        end
    end

    // stage 2: axis tests and squares
    logic [CW:0] ax_w, ay_w, az_w;
    logic        near_w;

    assign ax_w   = r1_dx[CW] ? (CW+1)'(-r1_dx) : r1_dx;
    assign ay_w   = r1_dy[CW] ? (CW+1)'(-r1_dy) : r1_dy;
    assign az_w   = r1_dz[CW] ? (CW+1)'(-r1_dz) : r1_dz;
    assign near_w = (ax_w <= (CW+1)'(r1_r)) && (ay_w <= (CW+1)'(r1_r))
                 && (az_w <= (CW+1)'(r1_r));

    logic                 r_v2;
    logic signed [CW-1:0] r2_px, r2_py, r2_pz, r2_y1;
    logic [RW-1:0]        r2_r, r2_ax, r2_az;
    logic                 r2_sx, r2_sz, r2_near;
    logic signed [CW+2:0] r2_rise;
    logic [D2W-1:0]       r2_x2, r2_y2, r2_z2, r2_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_pz   <= r1_pz;
            r2_y1   <= r1_y1;
            r2_r    <= r1_r;
            r2_ax   <= ax_w[RW-1:0];
            r2_az   <= az_w[RW-1:0];
            r2_sx   <= r1_dx[CW];
            r2_sz   <= r1_dz[CW];
            r2_near <= near_w;
            r2_rise <= r1_rise;
            r2_x2   <= ax_w[RW-1:0] * ax_w[RW-1:0];
            r2_y2   <= ay_w[RW-1:0] * ay_w[RW-1:0];
            r2_z2   <= az_w[RW-1:0] * az_w[RW-1:0];
            r2_r2   <= r1_r * r1_r;
        end
    end

    // stage 3: decide
    logic [D2W:0]         h2_w;
    logic [D2W+1:0]       d2_w;
    logic                 step_w;
    t_outcome             oc_w;
    logic signed [CW+1:0] ny_w;
    t_side                s3_w;

    assign h2_w   = (D2W+1)'(r2_x2) + (D2W+1)'(r2_z2);
    assign d2_w   = (D2W+2)'(h2_w) + (D2W+2)'(r2_y2);
    assign step_w = (h2_w <= (D2W+1)'(r2_r2)) && (r2_rise > 0)
                 && (r2_rise <= (CW+3)'({1'b0, r_step}));
    assign ny_w   = (CW+2)'(r2_y1) + (CW+2)'({1'b0, r_foot});

    always_comb begin
        if (!r2_near || d2_w > (D2W+2)'(r2_r2)) begin
            oc_w = OC_NONE;
        end else if (step_w) begin
            oc_w = OC_STEP;
        end else if (d2_w == '0) begin
            oc_w = OC_ZERO;
        end else begin
            oc_w = OC_PUSH;
        end
        s3_w.px      = r2_px;
        s3_w.pz      = r2_pz;
        s3_w.ny      = (oc_w == OC_STEP) ? sat_coord(SUMW'(ny_w)) : r2_py;
        s3_w.outcome = oc_w;
        s3_w.sx      = r2_sx;
        s3_w.sz      = r2_sz;
        s3_w.ax      = r2_ax;
        s3_w.az      = r2_az;
        s3_w.r       = r2_r;
    end

    logic           r_v3;
    t_side          r3_s;
    logic [D2W-1:0] r3_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_s  <= s3_w;
            r3_d2 <= d2_w[D2W-1:0];
        end
    end

    // root stages
    logic [RW-1:0] dist_w;
    logic          r_sq_v [0:SQRT_N-1];
    t_side         r_sq_s [0:SQRT_N-1];

    sbc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_d2   (r3_d2),
        .o_root (dist_w)
    );

    for (genvar g = 0; g < SQRT_N; g++) begin : g_sq_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[g] <= 1'b0;
            end else if (en) begin
                r_sq_v[g] <= (g == 0) ? r_v3 : r_sq_v[(g == 0) ? 0 : g-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_s[g] <= (g == 0) ? r3_s : r_sq_s[(g == 0) ? 0 : g-1];
            end
        end
    end

    // stage 4: overlap products
    t_side          sq_s;
    logic [RW-1:0]  ov_w;
    logic           r_v4;
    t_side          r4_s;
    logic [RW-1:0]  r4_dist;
    logic [D2W-1:0] r4_mx, r4_mz;

    assign sq_s = r_sq_s[SQRT_N-1];
    assign ov_w = sq_s.r - dist_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v4 <= r_sq_v[SQRT_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_s    <= sq_s;
            r4_dist <= dist_w;
            r4_mx   <= sq_s.ax * ov_w;
            r4_mz   <= sq_s.az * ov_w;
        end
    end

    // divide stages
    logic [D2W-1:0] qx_w, qz_w;
    logic           r_dv_v [0:DIV_N-1];
    t_side          r_dv_s [0:DIV_N-1];

    sbc_div u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r4_mx),
        .i_den (r4_dist),
        .o_quo (qx_w)
    );

    sbc_div u_div_z (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r4_mz),
        .i_den (r4_dist),
        .o_quo (qz_w)
    );

    for (genvar g = 0; g < DIV_N; g++) begin : g_dv_line
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[g] <= 1'b0;
            end else if (en) begin
                r_dv_v[g] <= (g == 0) ? r_v4 : r_dv_v[(g == 0) ? 0 : g-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_s[g] <= (g == 0) ? r4_s : r_dv_s[(g == 0) ? 0 : g-1];
            end
        end
    end

    // output stage
    t_side                dv_s;
    logic signed [SUMW-1:0] sum_x, sum_z;
    logic                 r_vo;
    logic signed [CW-1:0] r_nx, r_ny, r_nz;
    t_outcome             r_oc;

    assign dv_s  = r_dv_s[DIV_N-1];
    assign sum_x = SUMW'(dv_s.px) + (dv_s.sx ? -SUMW'(qx_w) : SUMW'(qx_w));
    assign sum_z = SUMW'(dv_s.pz) + (dv_s.sz ? -SUMW'(qz_w) : SUMW'(qz_w));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_dv_v[DIV_N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx <= (dv_s.outcome == OC_PUSH) ? sat_coord(sum_x) : dv_s.px;
            r_nz <= (dv_s.outcome == OC_PUSH) ? sat_coord(sum_z) : dv_s.pz;
            r_ny <= dv_s.ny;
            r_oc <= dv_s.outcome;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {r_nz, r_ny, r_nx};
    assign m_axis_tuser  = r_oc;

endmodule
`default_nettype wire

@@ rtl/sbc_checker.sv @@
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level assertions for the collision pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module sbc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        pready,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output free");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result beat dropped");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind sphere_box_collision_resolve sbc_checker u_sbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pready        (pready),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

@@ dv/sphere_box_collision_resolve_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sphere_box_collision_resolve_tb
// Streams sphere/box queries through the block with random valid and ready
// gaps. Each result beat is checked against an in-bench model under several
// foot_offset / max_step_rise settings, defaults and extremes included.
// ----------------------------------------------------------------------------
`default_nettype none
module sphere_box_collision_resolve_tb;
    import sbc_pkg::*;

    localparam int  LAT_WAIT = 80;
    localparam logic [2:0] ADDR_FOOT = 3'd0;
    localparam logic [2:0] ADDR_STEP = 3'd4;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct {
        t_coord        cx, cy, cz;
        logic [RW-1:0] rad;
        t_coord        x0, y0, z0, x1, y1, z1;
    } t_query;

    typedef struct {
        t_coord   nx, ny, nz;
        t_outcome oc;
    } t_resolved;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [239:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    sphere_box_collision_resolve u_dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_query        query_q[$];
    t_resolved     resolved_q[$];
    logic [RW-1:0] foot_cfg = FOOT_RESET;
    logic [RW-1:0] step_cfg = STEP_RESET;
    int            errors = 0;
    bit            tx_busy = 0;
    bit            in_beat = 0;
    bit            burst = 0;
    bit            hold = 0;

    function automatic longint clamp_ax(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint root_floor(longint unsigned n);
        longint unsigned root, bits;
        root = 0;
        bits = 64'd1 << 62;
        while (bits > n) bits >>= 2;
        while (bits != 0) begin
            if (n >= root + bits) begin
                n -= root + bits;
                root = (root >> 1) + bits;
            end else begin
                root >>= 1;
            end
            bits >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic t_coord sat_ax(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[CW-1:0];
    endfunction

    function automatic t_resolved resolve_contact(t_query q);
        longint px, py, pz, r, dx, dy, dz, rise, dlen, ov, nx, ny, nz;
        longint unsigned r2, h2, d2;
        t_resolved res;
        px = q.cx; py = q.cy; pz = q.cz;
        r = longint'(q.rad);
        nx = px; ny = py; nz = pz;
        res.oc = OC_NONE;
        dx = px - clamp_ax(px, q.x0, q.x1);
        dy = py - clamp_ax(py, q.y0, q.y1);
        dz = pz - clamp_ax(pz, q.z0, q.z1);
        if ((dx < 0 ? -dx : dx) <= r && (dy < 0 ? -dy : dy) <= r &&
            (dz < 0 ? -dz : dz) <= r) begin
            r2 = r * r;
            h2 = dx * dx + dz * dz;
            d2 = h2 + dy * dy;
            if (d2 <= r2) begin
                rise = longint'(q.y1) - py + longint'(foot_cfg);
                if (h2 <= r2 && rise > 0 && rise <= longint'(step_cfg)) begin
                    ny = longint'(q.y1) + longint'(foot_cfg);
                    res.oc = OC_STEP;
                end else if (d2 == 0) begin
                    res.oc = OC_ZERO;
                end else begin
                    dlen = root_floor(d2);
                    ov = r - dlen;
                    nx = px + (dx * ov) / dlen;
                    nz = pz + (dz * ov) / dlen;
                    res.oc = OC_PUSH;
                end
            end
        end
        res.nx = sat_ax(nx);
        res.ny = sat_ax(ny);
        res.nz = sat_ax(nz);
        return res;
    endfunction

    // driver
    t_query cur_q;
    int     tx_gap = 0;
    always @(negedge i_clk) begin
        if (tx_busy && in_beat) begin
            resolved_q.push_back(resolve_contact(cur_q));
            tx_busy = 0;
        end
        if (!tx_busy) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (query_q.size() > 0 && !hold) begin
                cur_q = query_q.pop_front();
                tx_busy = 1;
                tx_gap = burst ? 0 : $urandom_range(0, 8);
            end
        end
        s_axis_tvalid <= tx_busy;
        s_axis_tdata <= {4'b0, cur_q.z1, cur_q.y1, cur_q.x1, cur_q.z0, cur_q.y0, cur_q.x0,
                         cur_q.rad, cur_q.cz, cur_q.cy, cur_q.cx};
    end

    // result side stall
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (m_axis_tvalid && m_axis_tready) rx_gap = burst ? 0 : $urandom_range(0, 8);
        end
    end

    // monitor
    t_resolved want;
    always @(posedge i_clk) begin
        in_beat <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (resolved_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                want = resolved_q.pop_front();
                if (m_axis_tdata[23:0] !== want.nx) begin
                    $error("new_x exp %0d got %0d", want.nx, $signed(m_axis_tdata[23:0]));
                    errors++;
                end
                if (m_axis_tdata[47:24] !== want.ny) begin
                    $error("new_y exp %0d got %0d", want.ny, $signed(m_axis_tdata[47:24]));
                    errors++;
                end
                if (m_axis_tdata[71:48] !== want.nz) begin
                    $error("new_z exp %0d got %0d", want.nz, $signed(m_axis_tdata[71:48]));
                    errors++;
                end
                if (m_axis_tuser !== want.oc) begin
                    $error("outcome exp %0d got %0d", want.oc, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (addr == ADDR_FOOT) foot_cfg = data[RW-1:0];
        else step_cfg = data[RW-1:0];
    endtask

    task automatic drain();
        wait (query_q.size() == 0 && !tx_busy && resolved_q.size() == 0);
        repeat (LAT_WAIT) @(posedge i_clk);
    endtask

    function automatic t_coord near(t_coord c, int unsigned span);
        return sat_ax(longint'(c) + longint'($urandom_range(0, 2 * span)) - longint'(span));
    endfunction

    function automatic t_query rand_query();
        t_query q;
        int unsigned r, kind;
        t_coord tmp;
        kind = $urandom_range(0, 9);
        q.cx = $urandom; q.cy = $urandom; q.cz = $urandom;
        q.rad = $urandom; q.x0 = $urandom; q.y0 = $urandom; q.z0 = $urandom;
        q.x1 = $urandom; q.y1 = $urandom; q.z1 = $urandom;
        if (kind == 0) return q;
        r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20'hFFFFF) : $urandom_range(1, 8000);
        q.rad = r;
        q.x0 = near(q.cx, 2 * r); q.x1 = near(q.x0, 2 * r);
        q.z0 = near(q.cz, 2 * r); q.z1 = near(q.z0, 2 * r);
        q.y0 = near(q.cy, 2 * r); q.y1 = near(q.y0, 2 * r);
        if (kind <= 4) begin
            q.y1 = sat_ax(longint'(q.cy) - longint'(foot_cfg) +
                          longint'($urandom_range(0, step_cfg + 2)));
            q.y0 = near(q.y1, r) ;
            if (q.y0 > q.y1) q.y0 = q.y1;
        end
        if (kind == 9) begin
            tmp = q.x0; q.x0 = q.x1; q.x1 = tmp;
            tmp = q.z0; q.z0 = q.z1; q.z1 = tmp;
        end
        return q;
    endfunction

    function automatic t_query mk(t_coord cx, t_coord cy, t_coord cz, logic [RW-1:0] r,
                                  t_coord x0, t_coord y0, t_coord z0,
                                  t_coord x1, t_coord y1, t_coord z1);
        t_query q;
        q.cx = cx; q.cy = cy; q.cz = cz; q.rad = r;
        q.x0 = x0; q.y0 = y0; q.z0 = z0; q.x1 = x1; q.y1 = y1; q.z1 = z1;
        return q;
    endfunction

    localparam t_coord CMAX = 24'sh7FFFFF;
    localparam t_coord CMIN = -24'sh800000;

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, default registers
        query_q.push_back(mk(0, 0, 0, 256, 1000, 1000, 1000, 2000, 2000, 2000));   // far
        query_q.push_back(mk(0, 0, 0, 2560, -100, -5000, -100, 100, 0, 100));      // step
        query_q.push_back(mk(0, 0, 0, 2560, 500, -5000, -100, 900, 5000, 100));    // step
        query_q.push_back(mk(0, 0, 0, 256, -10, -10, -10, 10, 10, 10));            // inside
        query_q.push_back(mk(50, 0, 0, 2560, 100, -5000, 100, 0, 5000, -100));     // inverted
        query_q.push_back(mk(CMAX, CMAX, CMAX, 20'hFFFFF, CMIN, CMIN, CMIN,
                             CMAX - 1, CMAX - 300, CMAX - 1));
        query_q.push_back(mk(CMIN, CMIN, CMIN, 20'hFFFFF, CMIN + 5000, CMIN, CMIN + 5000,
                             CMAX, CMIN + 2000, CMAX));
        query_q.push_back(mk(CMAX, CMAX - 2000, CMAX, 20'hFFFFF, CMAX - 10, CMAX - 3000,
                             CMAX - 10, CMAX, CMAX - 2100, CMAX));
        query_q.push_back(mk(CMIN, CMAX, CMIN, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        query_q.push_back(mk(0, 0, 0, 0, 1, 1, 1, 2, 2, 2));
        query_q.push_back(mk(-1, -1, -1, 20'hFFFFF, 0, 0, 0, 0, 0, 0));
        drain();

        apb_write(ADDR_FOOT, 32'hFFFFFFFF);
        apb_write(ADDR_STEP, 32'hFFFFFFFF);
        query_q.push_back(mk(0, CMAX - 100, 0, 20'hFFFFF, -10, CMAX - 200, -10,
                             10, CMAX - 150, 10));                                    // step sat
        query_q.push_back(mk(0, 0, 0, 2560, -100, -5000, -100, 100, 0, 100));
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin apb_write(ADDR_FOOT, 0); apb_write(ADDR_STEP, 0); end
                1: begin apb_write(ADDR_FOOT, FOOT_RESET); apb_write(ADDR_STEP, STEP_RESET); end
                2: begin apb_write(ADDR_FOOT, 20'hFFFFF); apb_write(ADDR_STEP, 20'hFFFFF); end
                default: begin
                    apb_write(ADDR_FOOT, $urandom_range(0, 20000));
                    apb_write(ADDR_STEP, $urandom);
                end
            endcase
            burst = (ph == 3);
            for (int k = 0; k < 225; k++) query_q.push_back(rand_query());
            if (ph == 4) begin
                wait (query_q.size() < 100);
                hold = 1;
                wait (!tx_busy && resolved_q.size() == 0);
                hold = 0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
